### hdl/pare_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pare_pkg
// shared types, constants and helpers for the particle record reorder engine
// ----------------------------------------------------------------------------
package pare_pkg;

  localparam int MAX_RECORDS = 1024;
  localparam int ADDR_W      = $clog2(MAX_RECORDS);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int COORD_W     = 32;
  localparam int TAG_W       = 10;
  localparam int POS_W       = 10;
  localparam int CFG_ADDR_W  = 1;
  localparam int CFG_DATA_W  = 2;

  // stream widths, rounded up to whole bytes
  localparam int IN_BITS     = 3 * COORD_W + TAG_W + POS_W;
  localparam int IN_DATA_W   = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS    = 3 * COORD_W + TAG_W;
  localparam int OUT_DATA_W  = ((OUT_BITS + 7) / 8) * 8;

  // operations carried in the input tuser
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_MODE = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_AXIS = 1'd1;

  // reorder modes
  localparam logic [1:0] MODE_KEEP = 2'd0;
  localparam logic [1:0] MODE_SORT = 2'd1;
  localparam logic [1:0] MODE_PART = 2'd2;

  // key axes
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic [COORD_W-1:0] z;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  // key coordinate of a record; unused axis code falls back to x
  function automatic logic [COORD_W-1:0] key_of(rec_t r, logic [1:0] axis);
    logic [COORD_W-1:0] k;
    case (axis)
      AXIS_Y:  k = r.y;
      AXIS_Z:  k = r.z;
      default: k = r.x;
    endcase
    return k;
  endfunction

endpackage

### hdl/pare_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pare_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module pare_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/particle_axis_reorder_engine_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// particle_axis_reorder_engine_top
// stores particle records and reorders them on one coordinate axis
// ----------------------------------------------------------------------------
// usage
//   in_* stream: in_tuser selects load (0) or read (1). a load stores one
//   record at the end of the set, in_tlast closes the set and starts the
//   reorder selected by reorder_mode on the key given by sort_axis.
//   a read returns one out_* transaction with the record at read_position;
//   out_tuser is 0 (and data zero) when the position is past the set.
//   cfg_* port writes reorder_mode (index 0) and sort_axis (index 1).
// timing
//   a read holds in_tready low until the registered ram data has moved into
//   the output register, which waits while that register is still full.
//   full sort: from the second record on, each record is held, larger keys
//   are shifted up one place and the record is written into the gap; its speed
//   is bounded by the single ram port pair and the one key comparator. partition:
//   negative records are swapped to the front, stopping once swaps reach half
//   the set size. in_tready is low while a reorder runs.
// reset and stall
//   reset empties the set and clears both registers; ram contents are kept.
//   a stalled output holds its transaction; loads are still taken, a
//   further read waits until the output register frees up.
// ----------------------------------------------------------------------------
module particle_axis_reorder_engine_top (
  input  logic                              clk,
  input  logic                              rst_n,
  // slave side
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // coord_x, coord_y, coord_z, record_tag, read_position
  input  logic [pare_pkg::IN_DATA_W-1:0]    in_tdata,
  // operation
  input  logic                              in_tuser,
  input  logic                              in_tlast,
  // master side
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // out_x, out_y, out_z, out_tag
  output logic [pare_pkg::OUT_DATA_W-1:0]   out_tdata,
  // out_valid
  output logic                              out_tuser,
  // configuration
  input  logic                              cfg_we,
  input  logic [pare_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [pare_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  import pare_pkg::*;

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_RD_WAIT  = 4'd1;
  localparam logic [3:0] ST_IS_RD_I  = 4'd2;
  localparam logic [3:0] ST_IS_GET_I = 4'd3;
  localparam logic [3:0] ST_IS_CMP   = 4'd4;
  localparam logic [3:0] ST_IS_PUT   = 4'd5;
  localparam logic [3:0] ST_PT_RD_I  = 4'd6;
  localparam logic [3:0] ST_PT_GET_I = 4'd7;
  localparam logic [3:0] ST_PT_SCAN  = 4'd8;
  localparam logic [3:0] ST_PT_CHK   = 4'd9;
  localparam logic [3:0] ST_PT_SW1   = 4'd10;
  localparam logic [3:0] ST_PT_SW2   = 4'd11;

  logic [3:0]             state_r, state_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   closed_r, closed_nxt;
  logic [1:0]             mode_r, mode_nxt;
  logic [1:0]             axis_r, axis_nxt;
  logic [CNT_W-1:0]       i_r, i_nxt;
  logic [ADDR_W-1:0]      j_r, j_nxt;
  logic [CNT_W-1:0]       fptr_r, fptr_nxt;
  logic [CNT_W-1:0]       swaps_r, swaps_nxt;
  rec_t                   rec_r, rec_nxt;
  rec_t                   recf_r, recf_nxt;
  logic [ADDR_W-1:0]      pos_r, pos_nxt;
  logic                   rd_ok_r, rd_ok_nxt;
  logic                   out_tvalid_r, out_tvalid_nxt;
  rec_t                   out_rec_r, out_rec_nxt;
  logic                   out_ok_r, out_ok_nxt;

  logic                   ram_we;
  logic [ADDR_W-1:0]      ram_waddr;
  rec_t                   ram_wdata;
  logic [ADDR_W-1:0]      ram_raddr;
  rec_t                   ram_rdata;

  logic                   in_fire;
  rec_t                   in_rec;
  logic [POS_W-1:0]       in_pos;
  logic [CNT_W-1:0]       base_cnt;
  logic [CNT_W-1:0]       half_cnt;
  logic signed [COORD_W-1:0] key_cur;
  logic signed [COORD_W-1:0] key_mem;
  logic                   key_lt;
  logic                   mem_neg;
  logic                   out_free;

  pare_ram #(
    .WIDTH (REC_W),
    .DEPTH (MAX_RECORDS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign in_rec     = rec_t'(in_tdata[REC_W-1:0]);
  assign in_pos     = in_tdata[REC_W +: POS_W];
  assign base_cnt   = closed_r ? '0 : cnt_r;
  assign half_cnt   = cnt_r >> 1;
  assign out_free   = !out_tvalid_r || out_tready;

  // key comparator for the sort, key sign test for the partition
  assign key_cur    = key_of(rec_r, axis_r);
  assign key_mem    = key_of(ram_rdata, axis_r);
  assign key_lt     = key_cur < key_mem;
  assign mem_neg    = key_mem[COORD_W-1];

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = OUT_DATA_W'(out_rec_r);
  assign out_tuser  = out_ok_r;

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    closed_nxt     = closed_r;
    mode_nxt       = mode_r;
    axis_nxt       = axis_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    fptr_nxt       = fptr_r;
    swaps_nxt      = swaps_r;
    rec_nxt        = rec_r;
    recf_nxt       = recf_r;
    pos_nxt        = pos_r;
    rd_ok_nxt      = rd_ok_r;
    out_tvalid_nxt = out_tvalid_r;
    out_rec_nxt    = out_rec_r;
    out_ok_nxt     = out_ok_r;
    ram_we         = 1'b0;
    ram_waddr      = j_r;
    ram_wdata      = rec_r;
    ram_raddr      = pos_r;

    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    if (cfg_we) begin
      case (cfg_addr)
        CFG_MODE: mode_nxt = cfg_wdata;
        CFG_AXIS: axis_nxt = cfg_wdata;
        default:  ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_tuser == OP_LOAD) begin
            cnt_nxt    = base_cnt;
            closed_nxt = in_tlast;
            if (base_cnt < CNT_W'(MAX_RECORDS)) begin
              ram_we    = 1'b1;
              ram_waddr = base_cnt[ADDR_W-1:0];
              ram_wdata = in_rec;
              cnt_nxt   = base_cnt + 1'b1;
            end
            if (in_tlast) begin
              if (mode_r == MODE_SORT) begin
                i_nxt     = CNT_W'(1);
                state_nxt = ST_IS_RD_I;
              end else if (mode_r == MODE_PART) begin
                i_nxt     = '0;
                fptr_nxt  = '0;
                swaps_nxt = '0;
                state_nxt = ST_PT_RD_I;
              end
            end
          end else begin
            pos_nxt   = in_pos;
            ram_raddr = in_pos;
            rd_ok_nxt = {1'b0, in_pos} < cnt_r;
            state_nxt = ST_RD_WAIT;
          end
        end
      end

      ST_RD_WAIT: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_ok_nxt     = rd_ok_r;
          out_rec_nxt    = rd_ok_r ? ram_rdata : '0;
          state_nxt      = ST_IDLE;
        end
      end

      // insertion sort: hold record i, shift larger ones up by one
      ST_IS_RD_I: begin
        if (i_r >= cnt_r) begin
          state_nxt = ST_IDLE;
        end else begin
          ram_raddr = i_r[ADDR_W-1:0];
          state_nxt = ST_IS_GET_I;
        end
      end

      ST_IS_GET_I: begin
        rec_nxt   = ram_rdata;
        j_nxt     = i_r[ADDR_W-1:0];
        ram_raddr = i_r[ADDR_W-1:0] - 1'b1;
        state_nxt = ST_IS_CMP;
      end

      ST_IS_CMP: begin
        if (key_lt) begin
          ram_we    = 1'b1;
          ram_waddr = j_r;
          ram_wdata = ram_rdata;
          j_nxt     = j_r - 1'b1;
          if (j_r > ADDR_W'(1)) begin
            ram_raddr = j_r - ADDR_W'(2);
          end else begin
            state_nxt = ST_IS_PUT;
          end
        end else begin
          state_nxt = ST_IS_PUT;
        end
      end

      ST_IS_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = j_r;
        ram_wdata = rec_r;
        i_nxt     = i_r + 1'b1;
        state_nxt = ST_IS_RD_I;
      end

      // partition: entries below fptr are known negative
      ST_PT_RD_I: begin
        if (i_r >= cnt_r) begin
          state_nxt = ST_IDLE;
        end else begin
          ram_raddr = i_r[ADDR_W-1:0];
          state_nxt = ST_PT_GET_I;
        end
      end

      ST_PT_GET_I: begin
        rec_nxt = ram_rdata;
        if (mem_neg) begin
          state_nxt = ST_PT_SCAN;
        end else if (swaps_r == half_cnt) begin
          state_nxt = ST_IDLE;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = ST_PT_RD_I;
        end
      end

      ST_PT_SCAN: begin
        if (fptr_r >= i_r) begin
          i_nxt     = i_r + 1'b1;
          state_nxt = ST_PT_RD_I;
        end else begin
          ram_raddr = fptr_r[ADDR_W-1:0];
          state_nxt = ST_PT_CHK;
        end
      end

      ST_PT_CHK: begin
        if (mem_neg) begin
          fptr_nxt  = fptr_r + 1'b1;
          state_nxt = ST_PT_SCAN;
        end else begin
          recf_nxt  = ram_rdata;
          state_nxt = ST_PT_SW1;
        end
      end

      ST_PT_SW1: begin
        ram_we    = 1'b1;
        ram_waddr = fptr_r[ADDR_W-1:0];
        ram_wdata = rec_r;
        state_nxt = ST_PT_SW2;
      end

      ST_PT_SW2: begin
        ram_we    = 1'b1;
        ram_waddr = i_r[ADDR_W-1:0];
        ram_wdata = recf_r;
        swaps_nxt = swaps_r + 1'b1;
        if ((swaps_r + 1'b1) == half_cnt) begin
          state_nxt = ST_IDLE;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = ST_PT_RD_I;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      closed_r     <= 1'b0;
      mode_r       <= MODE_KEEP;
      axis_r       <= AXIS_X;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      closed_r     <= closed_nxt;
      mode_r       <= mode_nxt;
      axis_r       <= axis_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r       <= i_nxt;
    j_r       <= j_nxt;
    fptr_r    <= fptr_nxt;
    swaps_r   <= swaps_nxt;
    rec_r     <= rec_nxt;
    recf_r    <= recf_nxt;
    pos_r     <= pos_nxt;
    rd_ok_r   <= rd_ok_nxt;
    out_rec_r <= out_rec_nxt;
    out_ok_r  <= out_ok_nxt;
  end

  // set size never passes capacity
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_RECORDS))
    else $error("record count above capacity");

  // a closing load always leaves the set closed
  a_close: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_tuser == OP_LOAD && in_tlast) |=> closed_r)
    else $error("set not closed after last load");

  // reorder writes stay inside the set
  a_wr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && state_r != ST_IDLE) |-> ({1'b0, ram_waddr} < cnt_r))
    else $error("reorder write outside the set");

  // partition scan pointer never overtakes the current index
  a_fptr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PT_CHK || state_r == ST_PT_SW1 || state_r == ST_PT_SW2)
      |-> (fptr_r < i_r))
    else $error("partition pointer past current index");

endmodule
